>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/epsg_pkg.sv
`default_nettype none

package epsg_pkg;

   // Fixed field widths
   localparam int PIN_LIMIT   = 8;
   localparam int MODE_W      = 3;
   localparam int MODES_W     = MODE_W * PIN_LIMIT;
   localparam int RATE_W      = 3;
   localparam int ACTION_W    = 3;
   localparam int CHANNEL_W   = 3;
   localparam int VALUE_W     = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int PWM_W       = 13;
   localparam int SERVO_W     = 15;
   localparam int DUTY_W      = 7;
   localparam int PULSE_W     = 16;
   localparam int CORR_W      = 7;
   localparam int THR_W       = PWM_W + 1;

   localparam logic [RATE_W-1:0] RATE_RESET = 3'd1;
   localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK       = 3'd0,
      ACT_WRITE_PIN  = 3'd1,
      ACT_WRITE_ALL  = 3'd2,
      ACT_WRITE_DUTY = 3'd3,
      ACT_WRITE_SERVO = 3'd4
   } action_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_INPUT  = 3'd0,
      MODE_OUTPUT = 3'd1,
      MODE_ANALOG = 3'd2,
      MODE_SERVO  = 3'd3,
      MODE_LED    = 3'd4,
      MODE_PWM    = 3'd5
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODES = 2'd0,
      CSR_RATE  = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [MODES_W-1:0] modes;
      logic [RATE_W-1:0]  rate;
   } csr_type;

   // PWM period in counts for a rate index
   function automatic logic [PWM_W-1:0] pwm_period(input logic [RATE_W-1:0] sel);
      logic [PWM_W-1:0] p;
      case (sel)
         3'd0:    p = 13'd500;
         3'd1:    p = 13'd1000;
         3'd2:    p = 13'd2000;
         3'd3:    p = 13'd4000;
         3'd4:    p = 13'd8000;
         default: p = 13'd1000;
      endcase
      return p;
   endfunction

   // Counts per duty percent for a rate index
   function automatic logic [CORR_W-1:0] pwm_correction(input logic [RATE_W-1:0] sel);
      logic [CORR_W-1:0] c;
      case (sel)
         3'd0:    c = 7'd5;
         3'd1:    c = 7'd10;
         3'd2:    c = 7'd20;
         3'd3:    c = 7'd40;
         3'd4:    c = 7'd80;
         default: c = 7'd10;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/eight_channel_pwm_servo_generator_unit.sv
// A request is held in the request register, its result in the result register.
// Throughput: one request per cycle unless the result side stalls; the counter step,
// store write and level compare finish in the single pass between the two.
// Reset (synchronous, active high): counters, duties, pulses, level latch and
// pin modes clear to zero, the rate index returns to 1, both channels go empty.
`default_nettype none

`include "assert_macros.svh"

module eight_channel_pwm_servo_generator_unit #(
   parameter int CHANNELS     = 8,
   parameter int SERVO_PERIOD = 20000
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic [epsg_pkg::ACTION_W-1:0]      req_action,
   input  wire logic [epsg_pkg::CHANNEL_W-1:0]     req_channel,
   input  wire logic [epsg_pkg::VALUE_W-1:0]       req_value,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      logic [epsg_pkg::PIN_LIMIT-1:0]     rsp_pin_levels,
   output      logic [epsg_pkg::PIN_LIMIT-1:0]     rsp_drive_enable,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [epsg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [epsg_pkg::CSR_DATA_W-1:0]    csr_data
);
   import epsg_pkg::*;

   localparam int PINS = CHANNELS < PIN_LIMIT ? CHANNELS : PIN_LIMIT;

   csr_type cfg;

   logic                 req_valid_ff;
   logic [ACTION_W-1:0]  req_action_ff;
   logic [CHANNEL_W-1:0] req_channel_ff;
   logic [VALUE_W-1:0]   req_value_ff;

   logic                 rsp_valid_ff;
   logic [PIN_LIMIT-1:0] rsp_pin_levels_ff;
   logic [PIN_LIMIT-1:0] rsp_drive_enable_ff;

   logic                 out_free;
   logic                 advance;

   logic [PWM_W-1:0]     pwm_count_in;
   logic [SERVO_W-1:0]   servo_count_in;
   logic [DUTY_W-1:0]    duty_in [PINS];
   logic [PULSE_W-1:0]   servo_width_in [PINS];
   logic [PIN_LIMIT-1:0] level_latch_in;
   logic [PIN_LIMIT-1:0] pin_levels;
   logic [PIN_LIMIT-1:0] drive_enable;

   // Move a request forward whenever the result slot is free or draining
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid_ff && out_free;
   assign req_ready = !req_valid_ff || out_free;

   epsg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   epsg_state #(
      .CHANNELS     (CHANNELS),
      .SERVO_PERIOD (SERVO_PERIOD)
   ) u_state (
      .clock          (clock),
      .reset          (reset),
      .apply          (advance),
      .action         (req_action_ff),
      .channel        (req_channel_ff),
      .value          (req_value_ff),
      .cfg            (cfg),
      .pwm_count_in   (pwm_count_in),
      .servo_count_in (servo_count_in),
      .duty_in        (duty_in),
      .servo_width_in (servo_width_in),
      .level_latch_in (level_latch_in)
   );

   epsg_levels #(
      .CHANNELS (CHANNELS)
   ) u_levels (
      .cfg          (cfg),
      .pwm_count    (pwm_count_in),
      .servo_count  (servo_count_in),
      .duty         (duty_in),
      .servo_width  (servo_width_in),
      .level_latch  (level_latch_in),
      .pin_levels   (pin_levels),
      .drive_enable (drive_enable)
   );

   // Hold the incoming request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_action_ff  <= req_action;
         req_channel_ff <= req_channel;
         req_value_ff   <= req_value;
      end
   end

   // Capture the result of the request that advances
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pin_levels_ff   <= pin_levels;
         rsp_drive_enable_ff <= drive_enable;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pin_levels   = rsp_pin_levels_ff;
   assign rsp_drive_enable = rsp_drive_enable_ff;

   // A request that advances always lands in the result slot
   `ASSERT_NEXT(a_advance_lands, clock, reset, advance, rsp_valid_ff,
                "advanced request did not produce a result")

   // A pin never reads high unless it is driven
   `ASSERT_ALWAYS(a_level_driven, clock, reset,
                  !rsp_valid_ff || ((rsp_pin_levels_ff & ~rsp_drive_enable_ff) == '0),
                  "undriven pin reported high")

endmodule

`default_nettype wire

>>> hw/rtl/epsg_csr.sv
`default_nettype none

module epsg_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [epsg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [epsg_pkg::CSR_DATA_W-1:0]    csr_data,
   output      epsg_pkg::csr_type                  cfg
);
   import epsg_pkg::*;

   logic [MODES_W-1:0] modes_ff, modes_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [MODE_W-1:0]  code;

   // Always take writes; the user must send configuration only while idle (not enforced)
   assign csr_ready = 1'b1;

   // Decode a write; keep a pin's mode on an unknown code, drop a bad rate
   always_comb begin
      modes_in = modes_ff;
      rate_in  = rate_ff;
      code     = '0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODES: begin
               for (int p = 0; p < PIN_LIMIT; p++) begin
                  code = csr_data[MODE_W*p +: MODE_W];
                  if (code <= MODE_PWM) begin
                     modes_in[MODE_W*p +: MODE_W] = code;
                  end
               end
            end
            CSR_RATE: begin
               if (csr_data[RATE_W-1:0] < 3'd5) begin
                  rate_in = csr_data[RATE_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modes_ff <= '0;
         rate_ff  <= RATE_RESET;
      end else begin
         modes_ff <= modes_in;
         rate_ff  <= rate_in;
      end
   end

   assign cfg.modes = modes_ff;
   assign cfg.rate  = rate_ff;

endmodule

`default_nettype wire

>>> hw/rtl/epsg_state.sv
`default_nettype none

`include "assert_macros.svh"

module epsg_state #(
   parameter int CHANNELS     = 8,
   parameter int SERVO_PERIOD = 20000
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             apply,
   input  wire logic [epsg_pkg::ACTION_W-1:0]    action,
   input  wire logic [epsg_pkg::CHANNEL_W-1:0]   channel,
   input  wire logic [epsg_pkg::VALUE_W-1:0]     value,
   input  wire epsg_pkg::csr_type                cfg,
   output      logic [epsg_pkg::PWM_W-1:0]       pwm_count_in,
   output      logic [epsg_pkg::SERVO_W-1:0]     servo_count_in,
   output      logic [epsg_pkg::DUTY_W-1:0]      duty_in [CHANNELS < 8 ? CHANNELS : 8],
   output      logic [epsg_pkg::PULSE_W-1:0]     servo_width_in [CHANNELS < 8 ? CHANNELS : 8],
   output      logic [epsg_pkg::PIN_LIMIT-1:0]   level_latch_in
);
   import epsg_pkg::*;

   localparam int PINS = CHANNELS < PIN_LIMIT ? CHANNELS : PIN_LIMIT;
   localparam logic [SERVO_W-1:0] SERVO_LIMIT = SERVO_W'(SERVO_PERIOD);

   logic [PWM_W-1:0]     pwm_count_ff;
   logic [SERVO_W-1:0]   servo_count_ff;
   logic [DUTY_W-1:0]    duty_ff [PINS];
   logic [PULSE_W-1:0]   servo_width_ff [PINS];
   logic [PIN_LIMIT-1:0] level_latch_ff;

   logic [PWM_W-1:0]     pwm_plus;
   logic [SERVO_W-1:0]   servo_plus;
   logic [DUTY_W-1:0]    duty_clamped;

   assign pwm_plus     = pwm_count_ff + 13'd1;
   assign servo_plus   = servo_count_ff + 15'd1;
   assign duty_clamped = (value > 16'd100) ? DUTY_MAX : value[DUTY_W-1:0];

   // Apply one request to the counters and the per-pin stores
   always_comb begin
      pwm_count_in   = pwm_count_ff;
      servo_count_in = servo_count_ff;
      level_latch_in = level_latch_ff;
      for (int i = 0; i < PINS; i++) begin
         duty_in[i]        = duty_ff[i];
         servo_width_in[i] = servo_width_ff[i];
      end
      if (apply) begin
         case (action)
            ACT_TICK: begin
               pwm_count_in   = (pwm_plus >= pwm_period(cfg.rate)) ? '0 : pwm_plus;
               servo_count_in = (servo_plus >= SERVO_LIMIT) ? '0 : servo_plus;
            end
            ACT_WRITE_PIN: begin
               for (int i = 0; i < PINS; i++) begin
                  if (channel == CHANNEL_W'(i) &&
                      cfg.modes[MODE_W*i +: MODE_W] == MODE_OUTPUT) begin
                     if (value == 16'd1) begin
                        level_latch_in[i] = 1'b1;
                     end else if (value == 16'd0) begin
                        level_latch_in[i] = 1'b0;
                     end
                  end
               end
            end
            ACT_WRITE_ALL: begin
               for (int i = 0; i < PINS; i++) begin
                  if (cfg.modes[MODE_W*i +: MODE_W] == MODE_OUTPUT) begin
                     level_latch_in[i] = value[i];
                  end
               end
            end
            ACT_WRITE_DUTY: begin
               for (int i = 0; i < PINS; i++) begin
                  if (channel == CHANNEL_W'(i)) begin
                     duty_in[i] = duty_clamped;
                  end
               end
            end
            ACT_WRITE_SERVO: begin
               for (int i = 0; i < PINS; i++) begin
                  if (channel == CHANNEL_W'(i)) begin
                     servo_width_in[i] = value;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_count_ff   <= '0;
         servo_count_ff <= '0;
         level_latch_ff <= '0;
         for (int i = 0; i < PINS; i++) begin
            duty_ff[i]        <= '0;
            servo_width_ff[i] <= '0;
         end
      end else begin
         pwm_count_ff   <= pwm_count_in;
         servo_count_ff <= servo_count_in;
         level_latch_ff <= level_latch_in;
         for (int i = 0; i < PINS; i++) begin
            duty_ff[i]        <= duty_in[i];
            servo_width_ff[i] <= servo_width_in[i];
         end
      end
   end

   // The servo counter never reaches its wrap value
   `ASSERT_ALWAYS(a_servo_wrap, clock, reset, servo_count_ff < SERVO_LIMIT,
                  "servo counter past its period")

   // Stored duty stays clamped on every pin
   for (genvar g = 0; g < PINS; g++) begin : g_duty_chk
      `ASSERT_ALWAYS(a_duty_clamp, clock, reset, duty_ff[g] <= DUTY_MAX,
                     "stored duty above the clamp")
   end

endmodule

`default_nettype wire

>>> hw/rtl/epsg_levels.sv
`default_nettype none

module epsg_levels #(
   parameter int CHANNELS = 8
) (
   input  wire epsg_pkg::csr_type                cfg,
   input  wire logic [epsg_pkg::PWM_W-1:0]       pwm_count,
   input  wire logic [epsg_pkg::SERVO_W-1:0]     servo_count,
   input  wire logic [epsg_pkg::DUTY_W-1:0]      duty [CHANNELS < 8 ? CHANNELS : 8],
   input  wire logic [epsg_pkg::PULSE_W-1:0]     servo_width [CHANNELS < 8 ? CHANNELS : 8],
   input  wire logic [epsg_pkg::PIN_LIMIT-1:0]   level_latch,
   output      logic [epsg_pkg::PIN_LIMIT-1:0]   pin_levels,
   output      logic [epsg_pkg::PIN_LIMIT-1:0]   drive_enable
);
   import epsg_pkg::*;

   localparam int PINS = CHANNELS < PIN_LIMIT ? CHANNELS : PIN_LIMIT;

   logic [CORR_W-1:0] corr;

   assign corr = pwm_correction(cfg.rate);

   // Resolve each pin from its mode
   for (genvar g = 0; g < PIN_LIMIT; g++) begin : g_pin
      if (g < PINS) begin : g_live
         logic [MODE_W-1:0] mode;
         logic [THR_W-1:0]  threshold;
         logic              lvl;
         logic              drv;

         assign mode      = cfg.modes[MODE_W*g +: MODE_W];
         assign threshold = THR_W'(duty[g]) * THR_W'(corr);

         always_comb begin
            lvl = 1'b0;
            drv = 1'b0;
            case (mode)
               MODE_OUTPUT: begin
                  lvl = level_latch[g];
                  drv = 1'b1;
               end
               MODE_SERVO: begin
                  lvl = {1'b0, servo_count} <= servo_width[g];
                  drv = 1'b1;
               end
               MODE_PWM: begin
                  lvl = (duty[g] != '0) && ({1'b0, pwm_count} <= threshold);
                  drv = 1'b1;
               end
               MODE_LED: begin
                  drv = 1'b1;
               end
               default: ;
            endcase
         end

         assign pin_levels[g]   = lvl;
         assign drive_enable[g] = drv;
      end else begin : g_idle
         assign pin_levels[g]   = 1'b0;
         assign drive_enable[g] = 1'b0;
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/tb_eight_channel_pwm_servo_generator_unit.sv
`default_nettype none

module tb_eight_channel_pwm_servo_generator_unit;
   import epsg_pkg::*;

   localparam int SERVO_WRAP   = 20000;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASE_ITEMS  = 115;
   localparam int PHASES       = 6;
   localparam int SWEEP_TICKS  = 520;

   // Index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   // Action codes with no operation behind them
   localparam logic [ACTION_W-1:0] ACT_RESERVED_A = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_RESERVED_B = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_RESERVED_C = 3'd7;

   // Mode words with every pin on one code
   localparam logic [MODES_W-1:0] ALL_OUTPUT  = 24'h249249;
   localparam logic [MODES_W-1:0] ALL_SERVO   = 24'h6DB6DB;
   localparam logic [MODES_W-1:0] ALL_PWM     = 24'hB6DB6D;
   localparam logic [MODES_W-1:0] ALL_UNKNOWN = 24'hFFFFFF;

   // Pin 7 on the left, pin 0 on the right
   localparam logic [MODES_W-1:0] MIX_MODES = {MODE_INPUT, MODE_PWM, MODE_ANALOG, MODE_LED,
                                                MODE_PWM, MODE_SERVO, MODE_OUTPUT, MODE_OUTPUT};
   localparam logic [MODES_W-1:0] SWEEP_MODES = {MODE_OUTPUT, MODE_PWM, MODE_PWM, MODE_PWM,
                                                  MODE_SERVO, MODE_SERVO, MODE_SERVO, MODE_SERVO};

   typedef struct packed {
      logic [PIN_LIMIT-1:0] levels;
      logic [PIN_LIMIT-1:0] drive;
   } pin_snapshot_type;

   // Pin state model and queue of expected pin snapshots
   class pin_scoreboard_type;
      logic [MODES_W-1:0]                  modes;
      logic [RATE_W-1:0]                   rate;
      logic [PWM_W-1:0]                    pwm_count;
      logic [SERVO_W-1:0]                  servo_count;
      logic [PIN_LIMIT-1:0][DUTY_W-1:0]    duty;
      logic [PIN_LIMIT-1:0][PULSE_W-1:0]   pulse;
      logic [PIN_LIMIT-1:0]                latch;
      pin_snapshot_type                    expected_q[$];
      int                                  mismatches;
      int                                  checked;
      int                                  requests;
      int                                  ticks;
      int                                  csr_writes;

      function new();
         modes       = '0;
         rate        = RATE_RESET;
         pwm_count   = '0;
         servo_count = '0;
         duty        = '0;
         pulse       = '0;
         latch       = '0;
         mismatches  = 0;
         checked     = 0;
         requests    = 0;
         ticks       = 0;
         csr_writes  = 0;
      endfunction

      function logic [MODE_W-1:0] pin_mode(int p);
         return modes[MODE_W*p +: MODE_W];
      endfunction

      function int period_counts(int sel);
         case (sel)
            0:       return 500;
            2:       return 2000;
            3:       return 4000;
            4:       return 8000;
            default: return 1000;
         endcase
      endfunction

      // Track a register write; unknown codes keep the old pin mode
      function void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         logic [MODES_W-1:0] next;
         logic [MODE_W-1:0]  code;
         int                 p;
         csr_writes++;
         next = modes;
         case (idx)
            CSR_MODES: begin
               for (p = 0; p < PIN_LIMIT; p++) begin
                  code = data[MODE_W*p +: MODE_W];
                  if (code > MODE_PWM) code = modes[MODE_W*p +: MODE_W];
                  next[MODE_W*p +: MODE_W] = code;
               end
               modes = next;
            end
            CSR_RATE: begin
               if (data[RATE_W-1:0] < 5) rate = data[RATE_W-1:0];
            end
            default: ;
         endcase
      endfunction

      // Apply one accepted request and queue the pin snapshot it yields
      function void note_request(logic [ACTION_W-1:0] act, logic [CHANNEL_W-1:0] ch,
                                 logic [VALUE_W-1:0] val);
         int                sel;
         int                period;
         int                corr;
         int                p;
         logic [MODE_W-1:0] m;
         logic              hi;
         pin_snapshot_type  snap;
         sel    = (rate < 5) ? int'(rate) : 1;
         period = period_counts(sel);
         corr   = period / 100;
         requests++;
         case (act)
            ACT_TICK: begin
               ticks++;
               pwm_count = pwm_count + 1'b1;
               if (pwm_count >= period) pwm_count = '0;
               servo_count = servo_count + 1'b1;
               if (servo_count >= SERVO_WRAP) servo_count = '0;
            end
            ACT_WRITE_PIN: begin
               if (pin_mode(ch) == MODE_OUTPUT) begin
                  if (val == 16'd1) latch[ch] = 1'b1;
                  else if (val == 16'd0) latch[ch] = 1'b0;
               end
            end
            ACT_WRITE_ALL: begin
               for (p = 0; p < PIN_LIMIT; p++)
                  if (pin_mode(p) == MODE_OUTPUT) latch[p] = val[p];
            end
            ACT_WRITE_DUTY: duty[ch] = (val > DUTY_MAX) ? DUTY_MAX : val[DUTY_W-1:0];
            ACT_WRITE_SERVO: pulse[ch] = val;
            default: ;
         endcase

         // Derive each pin level from its mode
         for (p = 0; p < PIN_LIMIT; p++) begin
            m  = pin_mode(p);
            hi = 1'b0;
            case (m)
               MODE_OUTPUT: hi = latch[p];
               MODE_SERVO:  hi = (servo_count <= pulse[p]);
               MODE_PWM:    hi = (duty[p] != 0) && (int'(pwm_count) <= int'(duty[p]) * corr);
               default:     hi = 1'b0;
            endcase
            snap.levels[p] = hi;
            snap.drive[p]  = (m == MODE_OUTPUT) || (m == MODE_SERVO) ||
                             (m == MODE_LED) || (m == MODE_PWM);
         end
         expected_q.push_back(snap);
      endfunction

      function void report_mismatch(string field, logic [PIN_LIMIT-1:0] exp_v,
                                    logic [PIN_LIMIT-1:0] got_v);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("mismatch on %s at result %0d: expected %08b, got %08b",
                     field, checked, exp_v, got_v);
      endfunction

      // Compare one accepted result against the oldest snapshot
      function void check_response(logic [PIN_LIMIT-1:0] levels, logic [PIN_LIMIT-1:0] drive);
         pin_snapshot_type exp_s;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("result with no request outstanding: levels %08b drive %08b",
                        levels, drive);
            return;
         end
         exp_s = expected_q.pop_front();
         if (exp_s.levels !== levels) report_mismatch("pin_levels", exp_s.levels, levels);
         if (exp_s.drive !== drive) report_mismatch("drive_enable", exp_s.drive, drive);
         checked++;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ACTION_W-1:0]    req_action = '0;
   logic [CHANNEL_W-1:0]   req_channel = '0;
   logic [VALUE_W-1:0]     req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b1;
   logic [PIN_LIMIT-1:0]   rsp_pin_levels;
   logic [PIN_LIMIT-1:0]   rsp_drive_enable;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   bit                     calm = 1'b0;
   pin_scoreboard_type     sb;

   eight_channel_pwm_servo_generator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_channel      (req_channel),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pin_levels   (rsp_pin_levels),
      .rsp_drive_enable (rsp_drive_enable),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // Send one request, with an optional idle burst in front of it
   task automatic send_request(input logic [ACTION_W-1:0] act, input logic [CHANNEL_W-1:0] ch,
                               input logic [VALUE_W-1:0] val);
      bit taken;
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_channel <= ch;
      req_value   <= val;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end
      sb.note_request(act, ch, val);
   endtask

   // Hold csr_valid high until the write is taken; the caller drops it
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end
      sb.apply_csr(idx, data);
   endtask

   task automatic configure(input logic [MODES_W-1:0] modes_word,
                            input logic [RATE_W-1:0] rate_code);
      logic [CSR_DATA_W-1:0] rate_word;
      rate_word = CSR_DATA_W'($urandom);
      rate_word[RATE_W-1:0] = rate_code;
      write_csr(CSR_MODES, modes_word);
      write_csr(CSR_RATE, rate_word);
      csr_valid <= 1'b0;
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   function automatic logic [MODES_W-1:0] random_modes();
      logic [MODES_W-1:0] w;
      int                 p;
      for (p = 0; p < PIN_LIMIT; p++) begin
         if ($urandom_range(0, 9) == 0) w[MODE_W*p +: MODE_W] = MODE_W'($urandom_range(6, 7));
         else w[MODE_W*p +: MODE_W] = MODE_W'($urandom_range(0, 5));
      end
      return w;
   endfunction

   // Weighted mix of ticks, writes and unknown actions
   task automatic random_request();
      int                   pick;
      logic [ACTION_W-1:0]  act;
      logic [CHANNEL_W-1:0] ch;
      logic [VALUE_W-1:0]   val;
      pick = $urandom_range(0, 99);
      ch   = CHANNEL_W'($urandom_range(0, PIN_LIMIT - 1));
      val  = VALUE_W'($urandom);
      if (pick < 48) begin
         act = ACT_TICK;
      end else if (pick < 63) begin
         act = ACT_WRITE_PIN;
         if ($urandom_range(0, 4) != 0) val = VALUE_W'($urandom_range(0, 1));
      end else if (pick < 73) begin
         act = ACT_WRITE_ALL;
      end else if (pick < 84) begin
         act = ACT_WRITE_DUTY;
         if ($urandom_range(0, 3) != 0) val = VALUE_W'($urandom_range(0, 120));
      end else if (pick < 95) begin
         act = ACT_WRITE_SERVO;
         if ($urandom_range(0, 3) != 0) val = VALUE_W'($urandom_range(0, 1200));
      end else begin
         act = ACTION_W'($urandom_range(int'(ACT_RESERVED_A), int'(ACT_RESERVED_C)));
      end
      send_request(act, ch, val);
   endtask

   // Stall the result side in random bursts until the quiet tail
   initial begin : rsp_stall
      int n;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Sample results before the edge, check them at the edge
   initial begin : rsp_monitor
      logic                 got;
      logic [PIN_LIMIT-1:0] lv;
      logic [PIN_LIMIT-1:0] de;
      forever begin
         @(negedge clock);
         got = rsp_valid && rsp_ready;
         lv  = rsp_pin_levels;
         de  = rsp_drive_enable;
         @(posedge clock);
         if (got === 1'b1) sb.check_response(lv, de);
      end
   end

   initial begin : watchdog
      #5000000;
      $display("timeout: results still outstanding or handshake stuck");
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      int ph;
      int failures;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset state: all pins input, writes to them do nothing
      send_request(ACT_TICK, 3'd0, 16'h0000);
      send_request(ACT_WRITE_PIN, 3'd0, 16'd1);
      send_request(ACT_RESERVED_C, 3'd7, 16'hFFFF);
      drain();

      // Mixed pin modes, shortest PWM period
      configure(MIX_MODES, 3'd0);
      send_request(ACT_WRITE_PIN, 3'd0, 16'd1);
      send_request(ACT_WRITE_PIN, 3'd1, 16'd1);
      send_request(ACT_WRITE_PIN, 3'd0, 16'd2);
      send_request(ACT_WRITE_PIN, 3'd1, 16'hFFFF);
      send_request(ACT_WRITE_PIN, 3'd4, 16'd1);
      send_request(ACT_WRITE_ALL, 3'd5, 16'hFFFE);
      send_request(ACT_WRITE_ALL, 3'd2, 16'hAA01);
      send_request(ACT_WRITE_DUTY, 3'd3, 16'd100);
      send_request(ACT_WRITE_DUTY, 3'd6, 16'hFFFF);
      send_request(ACT_WRITE_DUTY, 3'd3, 16'd0);
      send_request(ACT_WRITE_DUTY, 3'd6, 16'd101);
      send_request(ACT_WRITE_SERVO, 3'd2, 16'hFFFF);
      send_request(ACT_WRITE_SERVO, 3'd2, 16'd0);
      send_request(ACT_WRITE_SERVO, 3'd7, 16'd12345);
      send_request(ACT_TICK, 3'd1, 16'h5555);
      send_request(ACT_TICK, 3'd6, 16'hAAAA);
      send_request(ACT_RESERVED_A, 3'd3, 16'd1);
      send_request(ACT_RESERVED_B, 3'd0, 16'd0);
      send_request(ACT_WRITE_DUTY, 3'd3, 16'd1);
      send_request(ACT_TICK, 3'd0, 16'd0);

      // Random traffic under a range of mode and rate settings
      for (ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: configure(ALL_OUTPUT, 3'd0);
            1: configure(ALL_PWM, 3'd0);
            2: configure(random_modes(), 3'd4);
            3: configure(ALL_SERVO, 3'd7);
            4: begin
               write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
               configure(ALL_UNKNOWN, RATE_W'($urandom_range(0, 7)));
            end
            default: configure(random_modes(), RATE_W'($urandom_range(0, 7)));
         endcase
         repeat (PHASE_ITEMS) random_request();
      end

      // Quiet tail: run the PWM counter through a full wrap
      calm = 1'b1;
      drain();
      configure(SWEEP_MODES, 3'd0);
      send_request(ACT_WRITE_SERVO, 3'd0, 16'd19999);
      send_request(ACT_WRITE_SERVO, 3'd1, 16'hFFFF);
      send_request(ACT_WRITE_SERVO, 3'd2, 16'd10000);
      send_request(ACT_WRITE_SERVO, 3'd3, 16'd0);
      send_request(ACT_WRITE_DUTY, 3'd4, 16'd100);
      send_request(ACT_WRITE_DUTY, 3'd5, 16'd1);
      send_request(ACT_WRITE_DUTY, 3'd6, 16'd37);
      send_request(ACT_WRITE_PIN, 3'd7, 16'd1);
      repeat (SWEEP_TICKS) send_request(ACT_TICK, CHANNEL_W'($urandom), VALUE_W'($urandom));

      drain();
      repeat (4) @(posedge clock);
      failures = sb.mismatches + sb.pending();
      $display("ran %0d requests (%0d ticks) over %0d register writes, %0d results checked",
               sb.requests, sb.ticks, sb.csr_writes, sb.checked);
      $display("mismatches: %0d, results never seen: %0d", sb.mismatches, sb.pending());
      if (failures == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
